// ===== rtl/i2f_pkg.sv =====
// ----------------------------------------------------------------------------
// i2f_pkg
// Shared types and constants for the integer to single-precision converter.
// ----------------------------------------------------------------------------
package i2f_pkg;

  localparam int unsigned IntW  = 32;
  localparam int unsigned FracW = 23;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned PosW  = 5;
  localparam logic [ExpW-1:0] ExpBias = 8'd127;

  typedef struct packed {
    logic            sign;
    logic            zero;
    logic [IntW-1:0] mag;
  } i2f_s1_t;

  typedef struct packed {
    logic            sign;
    logic            zero;
    logic [PosW-1:0] pos;
    logic [IntW-1:0] norm;
  } i2f_s2_t;

endpackage

// ===== rtl/i2f_lzc.sv =====
// ----------------------------------------------------------------------------
// i2f_lzc
// Leading-one position of a 32-bit word, found in a two-level tree.
// ----------------------------------------------------------------------------
module i2f_lzc (
  input  logic [i2f_pkg::IntW-1:0] data_i,
  output logic [i2f_pkg::PosW-1:0] pos_o
);
  import i2f_pkg::*;

  logic [3:0] grp_nz;
  logic [2:0] grp_pos [4];
  logic [1:0] top;

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      grp_nz[g]  = |data_i[g*8 +: 8];
      grp_pos[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (data_i[g*8+b]) begin
          grp_pos[g] = 3'(b);
        end
      end
    end
    top = 2'd0;
    for (int g = 0; g < 4; g++) begin
      if (grp_nz[g]) begin
        top = 2'(g);
      end
    end
    pos_o = {top, grp_pos[top]};
  end

endmodule

// ===== rtl/int32_to_float32.sv =====
// ----------------------------------------------------------------------------
// int32_to_float32
// Signed 32-bit integer to IEEE single conversion, round to nearest even.
// ----------------------------------------------------------------------------
// The input channel (in_valid_i, in_ready_o, int_value_i) takes one beat per
// clock cycle whilst in_ready_o is high. The output channel (out_valid_o,
// out_ready_i, float_bits_o) returns one beat for every input beat, in order.
// The work runs through four register stages: magnitude, leading-one search,
// normalising shift, and rounding with exponent assembly. Throughput is one
// beat per cycle whilst the receiver takes results.
// Each stage advances when it is empty or the stage after it advances, so a
// stall by the receiver holds every occupied stage and the empty ones still
// fill. Nothing is lost or repeated. Reset clears all valid bits; the block
// accepts input from the first cycle after reset.
// ----------------------------------------------------------------------------
module int32_to_float32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] int_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] float_bits_o
);
  import i2f_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  i2f_s1_t s1_q, s1_d;
  i2f_s2_t s2_q, s2_d, s3_q, s3_d;
  logic [31:0] res_q, res_d;
  logic [PosW-1:0] lz_pos;

  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o   = en1;
  assign out_valid_o  = v4_q;
  assign float_bits_o = res_q;

  always_comb begin
    s1_d.sign = int_value_i[31];
    s1_d.zero = (int_value_i == '0);
    s1_d.mag  = int_value_i[31] ? (32'd0 - int_value_i) : int_value_i;
  end

  i2f_lzc u_lzc (
    .data_i(s1_q.mag),
    .pos_o (lz_pos)
  );

  always_comb begin
    s2_d.sign = s1_q.sign;
    s2_d.zero = s1_q.zero;
    s2_d.pos  = lz_pos;
    s2_d.norm = s1_q.mag;
  end

  logic [PosW-1:0] sh;

  always_comb begin
    sh        = 5'd31 - s2_q.pos;
    s3_d      = s2_q;
    s3_d.norm = s2_q.norm << sh;
  end

  logic [23:0] sig;
  logic        grd, stk, rnd_up;
  logic [24:0] sig_r;
  logic [ExpW-1:0] expo;

  always_comb begin
    sig    = s3_q.norm[31:8];
    grd    = s3_q.norm[7];
    stk    = |s3_q.norm[6:0];
    rnd_up = grd && (stk || sig[0]);
    sig_r  = {1'b0, sig} + {24'd0, rnd_up};
    expo   = ExpBias + {3'd0, s3_q.pos} + {7'd0, sig_r[24]};
    if (s3_q.zero) begin
      res_d = '0;
    end else begin
      res_d = {s3_q.sign, expo, sig_r[24] ? 23'd0 : sig_r[22:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q  <= s1_d;
    if (en2) s2_q  <= s2_d;
    if (en3) s3_q  <= s3_d;
    if (en4) res_q <= res_d;
  end

endmodule
